@@ rtl/core/hbw_pkg.sv @@
// Shared types and constants of the multi-node heartbeat watchdog.
`default_nettype none

package hbw_pkg;

  typedef enum logic [1:0] {
    FUNC_REGISTER  = 2'd0,
    FUNC_HEARTBEAT = 2'd1,
    FUNC_REMOVE    = 2'd2,
    FUNC_TICK      = 2'd3
  } hbw_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } hbw_state_t;

  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 17;

  localparam logic [CfgIndexW-1:0] CFG_CHECK_PERIOD  = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_TIMEOUT_LIMIT = 8'd1;

  localparam logic [15:0] CHECK_PERIOD_RST  = 16'd1000;
  localparam logic [16:0] TIMEOUT_LIMIT_RST = 17'd1100;

  typedef struct packed {
    hbw_func_t   func;
    logic [2:0]  node_id;
  } hbw_in_t;

  typedef struct packed {
    logic [2:0]  stale_node;
    logic        last_of_scan;
  } hbw_out_t;

  typedef struct packed {
    logic        cmd_v;
    hbw_func_t   func;
    logic [2:0]  node_id;
    logic        shift;
  } hbw_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/hbw_cell.sv @@
// One node cell: valid mark, last-heard stamp and the scan token stage.
`default_nettype none

module hbw_cell import hbw_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hbw_ctrl_t   ctrl,
  input  wire logic [31:0] now,
  input  wire logic [16:0] limit,
  input  wire logic        token_in,
  output logic             token_out,
  output logic             hit
);

  logic        valid_r, valid_nxt;
  logic [31:0] last_r, last_nxt;
  logic        token_r, token_nxt;
  logic        match;
  logic [31:0] age;

  assign match = ctrl.cmd_v && (32'(ctrl.node_id) == 32'(IDX));

  always_comb begin
    valid_nxt = valid_r;
    last_nxt  = last_r;
    if (match) begin
      case (ctrl.func)
        FUNC_REGISTER: begin
          if (!valid_r) begin
            valid_nxt = 1'b1;
            last_nxt  = now;
          end
        end
        FUNC_HEARTBEAT: begin
          if (valid_r) begin
            last_nxt = now;
          end
        end
        FUNC_REMOVE: begin
          valid_nxt = 1'b0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
    token_nxt = ctrl.shift ? token_in : token_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      token_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

  assign age       = now - last_r;
  assign token_out = token_r;
  assign hit       = token_r && valid_r && (age > {15'd0, limit});

endmodule

`default_nettype wire

@@ rtl/core/multi_node_heartbeat_watchdog.sv @@
// Top level of the multi-node heartbeat watchdog.
// Register, heartbeat and remove transactions, and ticks that do not start a scan, are taken
// without stalling the input. A tick that completes a check period starts a scan: a token walks
// the row of NODES cells, one cell per cycle while the result register is free, then a flush
// state sends the final report; in_stall stays high from that tick until the flush ends.
// Stale nodes are reported in ascending index order, the last one with last_of_scan set.
`default_nettype none

module multi_node_heartbeat_watchdog import hbw_pkg::*; #(
  parameter int NODES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire hbw_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output hbw_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  localparam int IdxW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NODES - 1);

  hbw_state_t state_r, state_nxt;

  logic [15:0]     period_r;
  logic [16:0]     limit_r;
  logic [31:0]     now_r, now_nxt;
  logic [15:0]     tts_r, tts_nxt;
  logic [15:0]     tts_inc;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [2:0]      pend_id_r, pend_id_nxt;
  logic            out_valid_r, out_valid_nxt;
  hbw_out_t        out_data_r, out_data_nxt;

  logic            in_take, tick_take, start, step, out_free, hit_any;
  logic [IdxW+2:0] idx_ext;
  logic [NODES-1:0] hits;
  logic [NODES:0]   tokens;
  hbw_ctrl_t        ctrl;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign tick_take = in_take && (in_data.func == FUNC_TICK);
  assign tts_inc   = tts_r + 16'd1;
  assign start     = tick_take && (tts_inc >= period_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign step      = (state_r == ST_SCAN) && out_free;
  assign hit_any   = |hits;
  assign idx_ext   = {3'd0, idx_r};

  assign ctrl.cmd_v   = in_take && (in_data.func != FUNC_TICK);
  assign ctrl.func    = in_data.func;
  assign ctrl.node_id = in_data.node_id;
  assign ctrl.shift   = start || step;

  assign tokens[0] = start;

  for (genvar g = 0; g < NODES; g++) begin : g_cell
    hbw_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .now       (now_r),
      .limit     (limit_r),
      .token_in  (tokens[g]),
      .token_out (tokens[g+1]),
      .hit       (hits[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    tts_nxt       = tts_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_take) begin
          now_nxt = now_r + 32'd1;
          tts_nxt = tts_inc;
          if (start) begin
            tts_nxt    = 16'd0;
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (hit_any) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{stale_node: pend_id_r, last_of_scan: 1'b0};
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = idx_ext[2:0];
          end
          idx_nxt = idx_r + IdxW'(1);
          if (idx_r == LastIdx) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{stale_node: pend_id_r, last_of_scan: 1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      tts_r       <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= CHECK_PERIOD_RST;
      limit_r     <= TIMEOUT_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      tts_r       <= tts_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHECK_PERIOD:  period_r <= cfg_data[15:0];
          CFG_TIMEOUT_LIMIT: limit_r  <= cfg_data;
          default:           period_r <= period_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/hbw_checker.sv @@
// Port-level checker of the multi-node heartbeat watchdog and its bind.
`default_nettype none

module hbw_checker import hbw_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire hbw_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire hbw_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_cmd_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.func != FUNC_TICK) |=> !in_stall)
    else $error("A non-tick transaction started a scan.");

  a_mid_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_scan |-> in_stall)
    else $error("Scan ended before its last report was queued.");

endmodule

bind multi_node_heartbeat_watchdog hbw_checker u_hbw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ verif/multi_node_heartbeat_watchdog_tb.sv @@
// Self-checking testbench of the multi-node heartbeat watchdog.
`default_nettype none

module multi_node_heartbeat_watchdog_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbw_pkg::*;

  localparam int NodeCount  = 8;
  localparam int SettleWait = NodeCount + 8;
  localparam int CycleLimit = 400000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  hbw_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  hbw_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  hbw_in_t  pending_items[$];
  hbw_out_t stale_reports_due[$];
  int       queued_count   = 0;
  int       accepted_count = 0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  bit       no_idling      = 1'b0;

  logic [31:0] clock_ms   = '0;
  logic [15:0] since_scan = '0;
  logic [NodeCount-1:0] present = '0;
  logic [31:0] heard_at [NodeCount];
  logic [15:0] period_reg = CHECK_PERIOD_RST;
  logic [16:0] limit_reg  = TIMEOUT_LIMIT_RST;

  multi_node_heartbeat_watchdog #(.NODES(NodeCount)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("multi_node_heartbeat_watchdog_tb: errors");
      $finish;
    end
  end

  function automatic void predict_stale_reports(hbw_in_t item);
    hbw_out_t found[$];
    hbw_out_t report;
    logic [31:0] age;
    if (item.func == FUNC_REGISTER) begin
      if (!present[item.node_id]) begin
        present[item.node_id] = 1'b1;
        heard_at[item.node_id] = clock_ms;
      end
    end else if (item.func == FUNC_HEARTBEAT) begin
      if (present[item.node_id]) heard_at[item.node_id] = clock_ms;
    end else if (item.func == FUNC_REMOVE) begin
      present[item.node_id] = 1'b0;
    end else begin
      clock_ms = clock_ms + 32'd1;
      since_scan = since_scan + 16'd1;
      if (since_scan >= period_reg) begin
        since_scan = '0;
        for (int n = 0; n < NodeCount; n++) begin
          age = clock_ms - heard_at[n];
          if (present[n] && age > {15'd0, limit_reg}) begin
            report.stale_node = n[2:0];
            report.last_of_scan = 1'b0;
            found.push_back(report);
          end
        end
        if (found.size() > 0) found[found.size() - 1].last_of_scan = 1'b1;
        foreach (found[k]) stale_reports_due.push_back(found[k]);
      end
    end
  endfunction

  // Driver: a transaction is accepted when in_valid is high and in_stall is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_stale_reports(in_data);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (no_idling || $urandom_range(99) >= 9)) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    hbw_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stale_reports_due.size() == 0) begin
          $error("stale_node: expected none, got %0d", out_data.stale_node);
          mismatch_count++;
        end else begin
          want = stale_reports_due.pop_front();
          if (out_data.stale_node !== want.stale_node) begin
            $error("stale_node: expected %0d, got %0d", want.stale_node, out_data.stale_node);
            mismatch_count++;
          end
          if (out_data.last_of_scan !== want.last_of_scan) begin
            $error("last_of_scan: expected %0d, got %0d", want.last_of_scan,
                   out_data.last_of_scan);
            mismatch_count++;
          end
        end
      end
      out_stall <= !no_idling && ($urandom_range(99) < 9);
    end
  end

  task automatic queue_item(hbw_func_t f, logic [2:0] id);
    hbw_in_t item;
    item.func = f;
    item.node_id = id;
    pending_items.push_back(item);
    queued_count++;
  endtask

  task automatic queue_random(int count);
    int pick;
    hbw_func_t f;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) f = FUNC_TICK;
      else if (pick < 60) f = FUNC_REGISTER;
      else if (pick < 85) f = FUNC_HEARTBEAT;
      else f = FUNC_REMOVE;
      queue_item(f, 3'($urandom_range(7)));
    end
  endtask

  task automatic wait_quiet();
    while (accepted_count != queued_count || stale_reports_due.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHECK_PERIOD) period_reg = value[15:0];
    else if (idx == CFG_TIMEOUT_LIMIT) limit_reg = value;
  endtask

  task automatic set_config(logic [15:0] period, logic [16:0] limit);
    write_reg(CFG_CHECK_PERIOD, {1'b0, period});
    write_reg(CFG_TIMEOUT_LIMIT, limit);
  endtask

  initial begin
    foreach (heard_at[n]) heard_at[n] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_item(FUNC_REGISTER, 3'd0);
    queue_item(FUNC_REGISTER, 3'd7);
    queue_item(FUNC_REGISTER, 3'd0);
    queue_item(FUNC_HEARTBEAT, 3'd3);
    queue_item(FUNC_REMOVE, 3'd5);
    queue_item(FUNC_TICK, 3'd0);
    queue_item(FUNC_HEARTBEAT, 3'd0);
    queue_item(FUNC_TICK, 3'd7);
    queue_item(FUNC_REGISTER, 3'd3);
    queue_item(FUNC_REMOVE, 3'd3);
    for (int n = 1; n < NodeCount; n++) queue_item(FUNC_REGISTER, 3'(n));
    wait_quiet();

    set_config(16'd1, 17'd1);
    queue_item(FUNC_TICK, 3'd2);
    queue_item(FUNC_TICK, 3'd5);
    queue_item(FUNC_HEARTBEAT, 3'd4);
    queue_item(FUNC_REMOVE, 3'd6);
    queue_item(FUNC_TICK, 3'd1);
    wait_quiet();

    set_config(16'd65535, 17'd131071);
    queue_random(30);
    wait_quiet();

    set_config(16'd3, 17'd6);
    no_idling = 1'b1;
    queue_random(120);
    wait_quiet();
    no_idling = 1'b0;

    set_config(16'd2, 17'd4);
    queue_random(40);
    wait_quiet();
    queue_random(40);
    wait_quiet();

    set_config(16'($urandom_range(1, 6)), 17'($urandom_range(1, 20)));
    queue_random(60);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("multi_node_heartbeat_watchdog_tb: clean");
    end else begin
      $display("multi_node_heartbeat_watchdog_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
